@@ rtl/ifd_pkg.sv @@
// shared types and constants for the iir filter decimator
package ifd_pkg;

	// coefficient format, Q3.14 signed
	localparam int COEF_W = 18;

	// decimation factor register and phase counter widths
	localparam int DEC_W   = 7;
	localparam int PHASE_W = 6;
	localparam int MAX_DEC = 64;

	// configuration port widths
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = COEF_W;

	// reset value of the current-input numerator coefficient
	localparam logic signed [COEF_W-1:0] FF0_RESET = 18'sd16384;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FF0 = 4'd0,
		REG_FF1 = 4'd1,
		REG_FF2 = 4'd2,
		REG_FF3 = 4'd3,
		REG_FB1 = 4'd4,
		REG_FB2 = 4'd5,
		REG_FB3 = 4'd6,
		REG_DEC = 4'd7
	} cfg_reg_e;

	// full coefficient set handed to the filter datapath
	typedef struct packed {
		logic signed [COEF_W-1:0] ff0;
		logic signed [COEF_W-1:0] ff1;
		logic signed [COEF_W-1:0] ff2;
		logic signed [COEF_W-1:0] ff3;
		logic signed [COEF_W-1:0] fb1;
		logic signed [COEF_W-1:0] fb2;
		logic signed [COEF_W-1:0] fb3;
	} coef_set_t;

endpackage

@@ rtl/ifd_mac.sv @@
// combinational direct-form-i multiply-accumulate, rounding and saturation
module ifd_mac #(
	parameter int SAMPLE_BITS    = 16,
	parameter int COEF_FRAC_BITS = 14
) (
	input  ifd_pkg::coef_set_t              coef,
	input  logic signed [SAMPLE_BITS-1:0]   x0,
	input  logic signed [SAMPLE_BITS-1:0]   x1,
	input  logic signed [SAMPLE_BITS-1:0]   x2,
	input  logic signed [SAMPLE_BITS-1:0]   x3,
	input  logic signed [SAMPLE_BITS-1:0]   y1,
	input  logic signed [SAMPLE_BITS-1:0]   y2,
	input  logic signed [SAMPLE_BITS-1:0]   y3,
	output logic signed [SAMPLE_BITS-1:0]   y0,
	output logic                            sat
);
	import ifd_pkg::*;

	localparam int PROD_W = SAMPLE_BITS + COEF_W;
	// seven products plus rounding need three growth bits
	localparam int ACC_W  = PROD_W + 3;
	localparam int TOP_W  = ACC_W - SAMPLE_BITS + 1;

	localparam logic signed [ACC_W-1:0] RND =
		{{(ACC_W-1){1'b0}}, 1'b1} << (COEF_FRAC_BITS - 1);
	localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	logic signed [PROD_W-1:0] p_ff0, p_ff1, p_ff2, p_ff3;
	logic signed [PROD_W-1:0] p_fb1, p_fb2, p_fb3;
	logic signed [ACC_W-1:0]  acc;
	logic signed [ACC_W-1:0]  shifted;
	logic        [TOP_W-1:0]  top_bits;
	logic                     fits;

	// seven independent products
	assign p_ff0 = coef.ff0 * x0;
	assign p_ff1 = coef.ff1 * x1;
	assign p_ff2 = coef.ff2 * x2;
	assign p_ff3 = coef.ff3 * x3;
	assign p_fb1 = coef.fb1 * y1;
	assign p_fb2 = coef.fb2 * y2;
	assign p_fb3 = coef.fb3 * y3;

	// accumulate with half-lsb rounding offset
	assign acc = ACC_W'(p_ff0) + ACC_W'(p_ff1) + ACC_W'(p_ff2) + ACC_W'(p_ff3)
		- ACC_W'(p_fb1) - ACC_W'(p_fb2) - ACC_W'(p_fb3) + RND;

	// drop fraction bits, rounding toward plus infinity on ties
	assign shifted = acc >>> COEF_FRAC_BITS;

	// saturate to the sample range
	assign top_bits = shifted[ACC_W-1:SAMPLE_BITS-1];
	assign fits     = (&top_bits) | ~(|top_bits);
	assign sat      = ~fits;

	always_comb begin
		if (fits) begin
			y0 = shifted[SAMPLE_BITS-1:0];
		end else if (shifted[ACC_W-1]) begin
			y0 = Y_MIN;
		end else begin
			y0 = Y_MAX;
		end
	end

endmodule

@@ rtl/iir_filter_decimator.sv @@
// third-order direct-form-i iir filter with output decimation
//
// Usage:
//  s_axis carries one signed sample per transaction in tdata. m_axis carries
//  one filtered sample in tdata with the clip flag in tuser. The cfg channel
//  writes coefficients (indexes 0..6, Q3.14) and the decimation factor
//  (index 7); it is always ready and writes to other indexes are dropped.
//  Write configuration only while no sample is in flight.
//  Path: a sample is registered in the input stage, filtered combinationally
//  and its result is registered in the output stage before it shows on m_axis.
//  Throughput: one sample per cycle while m_axis does not stall; the
//  multiply-accumulate feeding the output history is combinational, so each
//  sample sees the previous filtered output right away.
//  Every dec-th filtered sample is sent, starting with the first; the others
//  still update the filter history.
//  Reset: histories and phase clear, coefficients go to a pass-through filter
//  (b0 = 1.0), factor 1, both stages empty.
//  Stall: when m_axis_tready is low, the result holds; one more sample waits
//  in the input stage and s_axis_tready drops only if that sample must
//  produce a result.
module iir_filter_decimator #(
	parameter int SAMPLE_BITS    = 16,
	parameter int COEF_FRAC_BITS = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample input
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_axis_tdata,   // sample_in
	// filtered output
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]  m_axis_tdata,   // sample_out
	output logic                              m_axis_tuser,   // saturated
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ifd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ifd_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ifd_pkg::*;

	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

	coef_set_t                      coef_q;
	logic [DEC_W-1:0]               dec_q;
	logic [PHASE_W-1:0]             phase_q;
	logic signed [SAMPLE_BITS-1:0]  x_hist_q [3];
	logic signed [SAMPLE_BITS-1:0]  y_hist_q [3];

	logic                           valid_s1;
	logic signed [SAMPLE_BITS-1:0]  sample_s1;

	logic                           out_valid_q;
	logic signed [SAMPLE_BITS-1:0]  out_sample_q;
	logic                           out_sat_q;

	logic signed [SAMPLE_BITS-1:0]  y_new;
	logic                           sat_new;
	logic                           emit;
	logic                           advance;
	logic [DEC_W-1:0]               dec_eff;
	logic [DEC_W-1:0]               phase_inc;

	// configuration port never stalls
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.ff0 <= FF0_RESET;
			coef_q.ff1 <= '0;
			coef_q.ff2 <= '0;
			coef_q.ff3 <= '0;
			coef_q.fb1 <= '0;
			coef_q.fb2 <= '0;
			coef_q.fb3 <= '0;
			dec_q      <= DEC_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FF0: coef_q.ff0 <= cfg_data;
				REG_FF1: coef_q.ff1 <= cfg_data;
				REG_FF2: coef_q.ff2 <= cfg_data;
				REG_FF3: coef_q.ff3 <= cfg_data;
				REG_FB1: coef_q.fb1 <= cfg_data;
				REG_FB2: coef_q.fb2 <= cfg_data;
				REG_FB3: coef_q.fb3 <= cfg_data;
				REG_DEC: dec_q      <= cfg_data[DEC_W-1:0];
				default: ;
			endcase
		end
	end

	// filter datapath on the registered sample
	ifd_mac #(
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_mac (
		.coef (coef_q),
		.x0   (sample_s1),
		.x1   (x_hist_q[0]),
		.x2   (x_hist_q[1]),
		.x3   (x_hist_q[2]),
		.y1   (y_hist_q[0]),
		.y2   (y_hist_q[1]),
		.y3   (y_hist_q[2]),
		.y0   (y_new),
		.sat  (sat_new)
	);

	// stage handshake: decimated-away samples never wait for the output
	assign emit          = (phase_q == '0);
	assign advance       = valid_s1 && (!emit || !out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	// effective factor, zero means one and large values clip to the maximum
	always_comb begin
		if (dec_q == '0) begin
			dec_eff = DEC_W'(1);
		end else if (dec_q > DEC_W'(MAX_DEC)) begin
			dec_eff = DEC_W'(MAX_DEC);
		end else begin
			dec_eff = dec_q;
		end
	end
	assign phase_inc = {1'b0, phase_q} + DEC_W'(1);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			sample_s1 <= s_axis_tdata[SAMPLE_BITS-1:0];
		end
	end

	// filter histories and decimation phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				x_hist_q[i] <= '0;
				y_hist_q[i] <= '0;
			end
			phase_q <= '0;
		end else if (advance) begin
			x_hist_q[2] <= x_hist_q[1];
			x_hist_q[1] <= x_hist_q[0];
			x_hist_q[0] <= sample_s1;
			y_hist_q[2] <= y_hist_q[1];
			y_hist_q[1] <= y_hist_q[0];
			y_hist_q[0] <= y_new;
			phase_q     <= (phase_inc >= dec_eff) ? '0 : phase_inc[PHASE_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_sample_q <= y_new;
			out_sat_q    <= sat_new;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_W'(unsigned'(out_sample_q));
	assign m_axis_tuser  = out_sat_q;

`ifndef SYNTH
	// an empty input stage always takes a sample
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stage empty but not ready");

	// the phase wraps once it reaches the effective factor
	a_phase_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (phase_inc >= dec_eff)) |=> (phase_q == '0))
		else $error("decimation phase did not wrap");

	// a new result only appears from an emitting sample
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && emit))
		else $error("result appeared without an emitting sample");

	// a decimated-away sample leaves a waiting result untouched
	a_drop_keeps_out: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !emit && out_valid_q && !m_axis_tready)
		|=> ($stable(out_sample_q) && $stable(out_sat_q) && out_valid_q))
		else $error("dropped sample disturbed the waiting result");
`endif

endmodule

@@ dv/iir_filter_decimator_tb.sv @@
// self-checking testbench for the iir filter decimator: stream driver, output checker, predictor
`timescale 1ns / 1ps

module iir_filter_decimator_tb;
	import ifd_pkg::*;

	localparam int SAMPLE_W     = 16;
	localparam int FRAC_BITS    = 14;
	localparam int DATA_W       = ((SAMPLE_W + 7) / 8) * 8;
	localparam int HIST_DEPTH   = 3;
	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 10;
	localparam int MAX_GAP      = 19;
	localparam int STALL_CYCLES = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 1600;
	localparam int TIMEOUT_NS   = 5_000_000;

	localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
	localparam longint ROUND_HALF = longint'(1) <<< (FRAC_BITS - 1);
	localparam int     COEF_MAX   = (1 <<< (COEF_W - 1)) - 1;
	localparam int     COEF_MIN   = -(1 <<< (COEF_W - 1));

	typedef enum int unsigned {
		COEF_FULL,
		COEF_MILD,
		COEF_EXTREME
	} coef_mode_e;

	typedef struct {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       saturated;
	} filt_result_t;

	// clock and reset
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// block inputs, all known from time zero
	logic              s_axis_tvalid = 1'b0;
	logic [DATA_W-1:0] s_axis_tdata  = '0;
	logic              m_axis_tready = 1'b0;
	logic              cfg_valid     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// block outputs
	logic              s_axis_tready;
	logic              m_axis_tvalid;
	logic [DATA_W-1:0] m_axis_tdata;
	logic              m_axis_tuser;
	logic              cfg_ready;

	// stimulus and expectation stores
	logic [SAMPLE_W-1:0] pending_samples [$];
	filt_result_t        expected_outputs [$];
	int unsigned         fail_count = 0;

	// idling and stall control
	bit          src_idle_en  = 1'b0;
	bit          sink_idle_en = 1'b0;
	logic [3:0]  stall_req    = '0;
	logic [3:0]  stall_ack;
	int unsigned stall_cnt;
	int unsigned src_gap;
	int unsigned sink_gap;

	// predicted filter state
	logic signed [COEF_W-1:0]   ff_coef [4];
	logic signed [COEF_W-1:0]   fb_coef [HIST_DEPTH];
	logic [DEC_W-1:0]           dec_factor;
	logic signed [SAMPLE_W-1:0] x_hist [HIST_DEPTH];
	logic signed [SAMPLE_W-1:0] y_hist [HIST_DEPTH];
	logic [PHASE_W-1:0]         dec_phase;

	iir_filter_decimator #(
		.SAMPLE_BITS   (SAMPLE_W),
		.COEF_FRAC_BITS(FRAC_BITS)
	) uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// filter state after reset: pass-through, factor one
	initial begin
		ff_coef[0] = FF0_RESET;
		for (int k = 1; k < 4; k++) ff_coef[k] = '0;
		for (int k = 0; k < HIST_DEPTH; k++) begin
			fb_coef[k] = '0;
			x_hist[k]  = '0;
			y_hist[k]  = '0;
		end
		dec_factor = DEC_W'(1);
		dec_phase  = '0;
	end

	function automatic int unsigned draw_gap(input bit idle_en);
		return idle_en ? $urandom_range(0, MAX_GAP) : 0;
	endfunction

	// one filter step: full-precision mac, round, saturate, history, decimation
	function automatic void predict_filter_output(input logic signed [SAMPLE_W-1:0] x);
		longint       acc;
		longint       y;
		logic         clipped;
		int unsigned  dec;
		int unsigned  next_phase;
		int           k;
		filt_result_t res;
		acc = longint'(ff_coef[0]) * longint'(x);
		for (k = 0; k < HIST_DEPTH; k++) begin
			acc += longint'(ff_coef[k+1]) * longint'(x_hist[k]);
			acc -= longint'(fb_coef[k]) * longint'(y_hist[k]);
		end
		y = (acc + ROUND_HALF) >>> FRAC_BITS;
		clipped = 1'b0;
		if (y > SAMPLE_MAX) begin
			y = SAMPLE_MAX;
			clipped = 1'b1;
		end else if (y < SAMPLE_MIN) begin
			y = SAMPLE_MIN;
			clipped = 1'b1;
		end
		for (k = HIST_DEPTH - 1; k > 0; k--) begin
			x_hist[k] = x_hist[k-1];
			y_hist[k] = y_hist[k-1];
		end
		x_hist[0] = x;
		y_hist[0] = y[SAMPLE_W-1:0];
		if (dec_phase == '0) begin
			res.sample_out = y[SAMPLE_W-1:0];
			res.saturated  = clipped;
			expected_outputs.push_back(res);
		end
		// zero acts as one, anything past the maximum is clamped
		dec = dec_factor;
		if (dec == 0) dec = 1;
		if (dec > MAX_DEC) dec = MAX_DEC;
		next_phase = dec_phase + 1;
		dec_phase = (next_phase >= dec) ? '0 : PHASE_W'(next_phase);
	endfunction

	// sample driver: one transaction per pending sample, random gaps
	always @(posedge clk or negedge arst_n) begin : drive_samples
		int unsigned gap;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			src_gap       <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			gap = src_gap;
			if (s_axis_tvalid) begin
				predict_filter_output(s_axis_tdata[SAMPLE_W-1:0]);
				gap = (stall_cnt != 0) ? 0 : draw_gap(src_idle_en);
			end else if (gap != 0) begin
				gap = (stall_cnt != 0) ? 0 : gap - 1;
			end
			if (gap == 0 && pending_samples.size() != 0) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= DATA_W'(pending_samples.pop_front());
			end else begin
				s_axis_tvalid <= 1'b0;
			end
			src_gap <= gap;
		end
	end

	// long receiver hold-off, started by the stimulus sequence
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_cnt <= 0;
			stall_ack <= '0;
		end else if (stall_ack != stall_req) begin
			stall_cnt <= STALL_CYCLES;
			stall_ack <= stall_req;
		end else if (stall_cnt != 0) begin
			stall_cnt <= stall_cnt - 1;
		end
	end

	// output monitor: compare each transaction with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : check_outputs
		int unsigned  gap;
		filt_result_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			sink_gap      <= 0;
		end else begin
			gap = sink_gap;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_outputs.size() == 0) begin
					$error("unexpected output transaction, sample_out %0d",
						$signed(m_axis_tdata[SAMPLE_W-1:0]));
					fail_count++;
				end else begin
					want = expected_outputs.pop_front();
					if (m_axis_tdata[SAMPLE_W-1:0] !== want.sample_out) begin
						$error("sample_out mismatch: expected %0d, actual %0d",
							want.sample_out, $signed(m_axis_tdata[SAMPLE_W-1:0]));
						fail_count++;
					end
					if (m_axis_tuser !== want.saturated) begin
						$error("saturated mismatch: expected %0b, actual %0b",
							want.saturated, m_axis_tuser);
						fail_count++;
					end
				end
				gap = draw_gap(sink_idle_en);
			end else if (gap != 0) begin
				gap = gap - 1;
			end
			sink_gap      <= gap;
			m_axis_tready <= (gap == 0) && (stall_cnt == 0);
		end
	end

	// one configuration transaction, mirrored into the predictor
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_FF0, REG_FF1, REG_FF2, REG_FF3: ff_coef[idx] = val;
			REG_FB1, REG_FB2, REG_FB3: fb_coef[idx - REG_FB1] = val;
			REG_DEC: dec_factor = val[DEC_W-1:0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic set_coefs(input logic [CFG_DATA_W-1:0] b0, b1, b2, b3, a1, a2, a3);
		write_reg(REG_FF0, b0);
		write_reg(REG_FF1, b1);
		write_reg(REG_FF2, b2);
		write_reg(REG_FF3, b3);
		write_reg(REG_FB1, a1);
		write_reg(REG_FB2, a2);
		write_reg(REG_FB3, a3);
	endtask

	// wait until every sample is taken and every result is back, then let the pipe settle;
	// checked at the falling edge so the driver and monitor updates have landed
	task automatic wait_for_drain();
		do @(negedge clk);
		while (pending_samples.size() != 0 || s_axis_tvalid || expected_outputs.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] rand_coef(input coef_mode_e mode, input bit feedback);
		int v;
		case (mode)
			COEF_FULL: v = int'($urandom_range(0, (1 << COEF_W) - 1));
			COEF_MILD: v = feedback ? int'($urandom_range(0, 8192)) - 4096
			                        : int'($urandom_range(0, 32768)) - 16384;
			default:   v = ($urandom_range(0, 1) != 0) ? COEF_MAX : COEF_MIN;
		endcase
		return CFG_DATA_W'(v);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_dec();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r <= 5) return CFG_DATA_W'($urandom_range(1, 4));
		if (r <= 7) return CFG_DATA_W'($urandom_range(5, MAX_DEC));
		if (r == 8) return ($urandom_range(0, 1) != 0) ? CFG_DATA_W'(0) : CFG_DATA_W'(MAX_DEC);
		return CFG_DATA_W'($urandom_range(MAX_DEC + 1, (1 << DEC_W) - 1));
	endfunction

	function automatic logic [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0:       return SAMPLE_W'(SAMPLE_MAX);
			1:       return SAMPLE_W'(SAMPLE_MIN);
			2:       return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
			default: return SAMPLE_W'($urandom());
		endcase
	endfunction

	// timeout guard
	initial begin
		#(TIMEOUT_NS);
		$display("FAIL");
		$finish;
	end

	// stimulus sequence
	initial begin : stimulus
		int         random_count;
		int         phase_no;
		int         n;
		bit         stall_phase;
		coef_mode_e mode;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// reset pass-through with the sample extremes
		@(negedge clk);
		pending_samples.push_back(SAMPLE_W'(0));
		pending_samples.push_back(SAMPLE_W'(SAMPLE_MAX));
		pending_samples.push_back(SAMPLE_W'(SAMPLE_MIN));
		pending_samples.push_back(SAMPLE_W'(1));
		pending_samples.push_back(SAMPLE_W'(-1));
		pending_samples.push_back(16'h5555);
		pending_samples.push_back(16'haaaa);
		wait_for_drain();

		// extreme coefficients drive saturation; factor zero acts as one
		set_coefs(CFG_DATA_W'(COEF_MAX), CFG_DATA_W'(COEF_MIN), CFG_DATA_W'(1),
			CFG_DATA_W'(-1), CFG_DATA_W'(COEF_MIN), CFG_DATA_W'(COEF_MAX), CFG_DATA_W'(0));
		write_reg(REG_DEC, CFG_DATA_W'(0));
		@(negedge clk);
		pending_samples.push_back(SAMPLE_W'(SAMPLE_MAX));
		pending_samples.push_back(SAMPLE_W'(SAMPLE_MIN));
		pending_samples.push_back(SAMPLE_W'(0));
		pending_samples.push_back(SAMPLE_W'(1));
		pending_samples.push_back(SAMPLE_W'(-1));
		pending_samples.push_back(SAMPLE_W'(SAMPLE_MAX));
		wait_for_drain();

		// half gain: exact halves round toward plus infinity
		set_coefs(CFG_DATA_W'(FF0_RESET / 2), '0, '0, '0, '0, '0, '0);
		write_reg(REG_DEC, CFG_DATA_W'(1));
		@(negedge clk);
		pending_samples.push_back(SAMPLE_W'(1));
		pending_samples.push_back(SAMPLE_W'(-1));
		pending_samples.push_back(SAMPLE_W'(3));
		pending_samples.push_back(SAMPLE_W'(-3));
		wait_for_drain();

		// factor above the maximum is clamped, then shrunk below the running phase
		set_coefs(CFG_DATA_W'(FF0_RESET), '0, '0, '0, '0, '0, '0);
		write_reg(REG_DEC, CFG_DATA_W'((1 << DEC_W) - 1));
		@(negedge clk);
		pending_samples.push_back(SAMPLE_W'(100));
		pending_samples.push_back(SAMPLE_W'(200));
		pending_samples.push_back(SAMPLE_W'(300));
		wait_for_drain();
		write_reg(REG_DEC, CFG_DATA_W'(2));
		// out-of-range index must not touch the current-input coefficient
		write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), '0);
		@(negedge clk);
		pending_samples.push_back(SAMPLE_W'(400));
		pending_samples.push_back(SAMPLE_W'(500));
		pending_samples.push_back(SAMPLE_W'(600));
		pending_samples.push_back(SAMPLE_W'(700));
		wait_for_drain();

		// random phases, each with a fresh coefficient set and factor
		random_count = 0;
		phase_no     = 0;
		while (random_count < RANDOM_ITEMS) begin
			stall_phase = (phase_no == 2) || (phase_no == 9);
			mode = stall_phase ? COEF_MILD : coef_mode_e'($urandom_range(0, 2));
			set_coefs(rand_coef(mode, 1'b0), rand_coef(mode, 1'b0), rand_coef(mode, 1'b0),
				rand_coef(mode, 1'b0), rand_coef(mode, 1'b1), rand_coef(mode, 1'b1),
				rand_coef(mode, 1'b1));
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_IDX_W'(int'(REG_DEC) + int'($urandom_range(1, 8))),
					CFG_DATA_W'($urandom()));
			write_reg(REG_DEC, stall_phase ? CFG_DATA_W'(1) : rand_dec());
			@(negedge clk);
			src_idle_en  <= stall_phase ? 1'b0 : bit'($urandom_range(0, 1));
			sink_idle_en <= stall_phase ? 1'b0 : bit'($urandom_range(0, 1));
			n = stall_phase ? 150 : int'($urandom_range(20, 120));
			repeat (n) pending_samples.push_back(rand_sample());
			if (stall_phase) stall_req <= stall_req + 1'b1;
			random_count += n;
			phase_no++;
			wait_for_drain();
		end

		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
